/* hdl/arp_pkg.sv */
// package: relocation codes, status codes and the stage record for the patch unit
package arp_pkg;

	// arm elf relocation codes that the unit handles
	localparam logic [7:0] RT_NONE            = 8'd0;
	localparam logic [7:0] RT_ABS32           = 8'd2;
	localparam logic [7:0] RT_REL32           = 8'd3;
	localparam logic [7:0] RT_THM_CALL        = 8'd10;
	localparam logic [7:0] RT_CALL            = 8'd28;
	localparam logic [7:0] RT_JUMP24          = 8'd29;
	localparam logic [7:0] RT_TARGET1         = 8'd38;
	localparam logic [7:0] RT_V4BX            = 8'd40;
	localparam logic [7:0] RT_TARGET2         = 8'd41;
	localparam logic [7:0] RT_PREL31          = 8'd42;
	localparam logic [7:0] RT_MOVW_ABS_NC     = 8'd43;
	localparam logic [7:0] RT_MOVT_ABS        = 8'd44;
	localparam logic [7:0] RT_THM_MOVW_ABS_NC = 8'd47;
	localparam logic [7:0] RT_THM_MOVT_ABS    = 8'd48;

	// status codes
	localparam logic [1:0] ST_PATCHED = 2'd0;
	localparam logic [1:0] ST_NOP     = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	// item after the address sums
	typedef struct packed {
		logic        valid;
		logic [7:0]  rtype;
		logic [31:0] word;
		logic [31:0] abs_val;
		logic [31:0] rel_val;
	} sum_t;

endpackage

/* hdl/arp_sum.sv */
// address sum stage: absolute and place-relative values of one item
module arp_sum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic [7:0]        rtype,
	input  logic [31:0]       addend,
	input  logic [31:0]       symbol_value,
	input  logic [31:0]       place_address,
	input  logic [31:0]       original_word,
	output arp_pkg::sum_t     sum
);
	import arp_pkg::*;

	logic [31:0] abs_c;
	logic [31:0] rel_c;
	logic        valid_s2;
	logic [7:0]  rtype_s2;
	logic [31:0] word_s2;
	logic [31:0] abs_s2;
	logic [31:0] rel_s2;

	// s + a and s + a - p, modulo 2^32
	always_comb begin
		abs_c = symbol_value + addend;
		rel_c = symbol_value + addend - place_address;
	end

	// valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		rtype_s2 <= rtype;
		word_s2  <= original_word;
		abs_s2   <= abs_c;
		rel_s2   <= rel_c;
	end

	// packed in field order: valid, rtype, word, abs_val, rel_val
	assign sum = {valid_s2, rtype_s2, word_s2, abs_s2, rel_s2};

endmodule

/* hdl/arp_patch.sv */
// patch stage: field splicing, branch range check and result register
module arp_patch (
	input  logic          clk,
	input  logic          arst_n,
	input  arp_pkg::sum_t sum,
	output logic          done,
	output logic [31:0]   patched_word,
	output logic [1:0]    status
);
	import arp_pkg::*;

	logic [31:0] val_c;
	logic [1:0]  st_c;
	logic        thm_ok;
	logic        arm_ok;
	logic        done_q;
	logic [31:0] word_q;
	logic [1:0]  status_q;

	// arm movw/movt immediate
	function automatic logic [31:0] arm_imm16(input logic [31:0] w, input logic [15:0] imm);
		arm_imm16 = (w & 32'hfff0f000) | {12'd0, imm[15:12], 4'd0, imm[11:0]};
	endfunction

	// thumb-2 movw/movt immediate
	function automatic logic [31:0] thumb_imm16(input logic [31:0] w, input logic [15:0] imm);
		logic [15:0] hi;
		logic [15:0] lo;
		hi = (w[15:0] & 16'hfbf0) | {5'd0, imm[11], 6'd0, imm[15:12]};
		lo = (w[31:16] & 16'h8f00) | {1'b0, imm[10:8], 4'd0, imm[7:0]};
		thumb_imm16 = {lo, hi};
	endfunction

	// thumb-2 bl / b.w offset
	function automatic logic [31:0] thumb_call(input logic [31:0] w, input logic [31:0] off);
		logic [15:0] hi;
		logic [15:0] lo;
		logic        s;
		logic        j1;
		logic        j2;
		s  = off[24];
		j1 = ~(s ^ off[23]);
		j2 = ~(s ^ off[22]);
		hi = (w[15:0] & 16'hf800) | {5'd0, s, off[21:12]};
		lo = (w[31:16] & 16'hd000) | {2'd0, j1, 1'b0, j2, off[11:1]};
		thumb_call = {lo, hi};
	endfunction

	// offset strictly inside +-2^24 and +-2^25 as sign-extension tests
	always_comb begin
		thm_ok = (sum.rel_val[31:24] == 8'h00) ||
			((sum.rel_val[31:24] == 8'hff) && (sum.rel_val[23:0] != 24'd0));
		arm_ok = (sum.rel_val[31:25] == 7'h00) ||
			((sum.rel_val[31:25] == 7'h7f) && (sum.rel_val[24:0] != 25'd0));
	end

	// select patch by relocation code
	always_comb begin
		val_c = 32'd0;
		st_c  = ST_PATCHED;
		case (sum.rtype)
			RT_V4BX: begin
				val_c = (sum.word & 32'hf000000f) | 32'h01a0f000;
			end
			RT_ABS32, RT_TARGET1: begin
				val_c = sum.abs_val;
			end
			RT_REL32, RT_TARGET2: begin
				val_c = sum.rel_val;
			end
			RT_THM_CALL: begin
				if (thm_ok) begin
					val_c = thumb_call(sum.word, sum.rel_val);
				end else begin
					st_c = ST_RANGE;
				end
			end
			RT_CALL, RT_JUMP24: begin
				if (arm_ok) begin
					val_c = (sum.word & 32'hff000000) | {8'd0, sum.rel_val[25:2]};
				end else begin
					st_c = ST_RANGE;
				end
			end
			RT_PREL31: begin
				val_c = sum.rel_val & 32'h7fffffff;
			end
			RT_MOVW_ABS_NC: begin
				val_c = arm_imm16(sum.word, sum.abs_val[15:0]);
			end
			RT_MOVT_ABS: begin
				val_c = arm_imm16(sum.word, sum.abs_val[31:16]);
			end
			RT_THM_MOVW_ABS_NC: begin
				val_c = thumb_imm16(sum.word, sum.abs_val[15:0]);
			end
			RT_THM_MOVT_ABS: begin
				val_c = thumb_imm16(sum.word, sum.abs_val[31:16]);
			end
			RT_NONE: begin
				st_c = ST_NOP;
			end
			default: begin
				st_c = ST_UNKNOWN;
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sum.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		word_q   <= val_c;
		status_q <= st_c;
	end

	assign done         = done_q;
	assign patched_word = word_q;
	assign status       = status_q;

endmodule

/* hdl/arm_elf_relocation_patch_unit.sv */
// top level of the arm elf relocation patch unit
// an accepted item passes the input, sum and result registers in turn; done rises from the result register
// throughput: one item per cycle, set by the three-stage pipeline; busy never rises
// the receiver cannot stall, so each result is shown for exactly one cycle
// reset clears the valid flags of all stages; payload registers are not reset
module arm_elf_relocation_patch_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  reloc_type,
	input  logic [31:0] addend,
	input  logic [31:0] symbol_value,
	input  logic [31:0] place_address,
	input  logic [31:0] original_word,
	output logic        done,
	output logic [31:0] patched_word,
	output logic [1:0]  status
);
	import arp_pkg::*;

	logic        valid_s1;
	logic [7:0]  rtype_s1;
	logic [31:0] addend_s1;
	logic [31:0] symbol_s1;
	logic [31:0] place_s1;
	logic [31:0] word_s1;
	sum_t        sum;

	// every stage advances each cycle
	assign busy = 1'b0;

	// input register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		rtype_s1  <= reloc_type;
		addend_s1 <= addend;
		symbol_s1 <= symbol_value;
		place_s1  <= place_address;
		word_s1   <= original_word;
	end

	// address sums
	arp_sum u_sum (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (valid_s1),
		.rtype         (rtype_s1),
		.addend        (addend_s1),
		.symbol_value  (symbol_s1),
		.place_address (place_s1),
		.original_word (word_s1),
		.sum           (sum)
	);

	// patch and result register
	arp_patch u_patch (
		.clk          (clk),
		.arst_n       (arst_n),
		.sum          (sum),
		.done         (done),
		.patched_word (patched_word),
		.status       (status)
	);

	// a result only follows an item in the sum stage
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(sum.valid))
		else $error("result without an item in flight");

	// anything but a patch gives a zero word
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_PATCHED) |-> (patched_word == 32'd0))
		else $error("non-zero word with non-patch status");

	// range errors only come from branch codes
	a_range_branch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RANGE) |->
		($past(sum.rtype) == RT_THM_CALL || $past(sum.rtype) == RT_CALL ||
		$past(sum.rtype) == RT_JUMP24))
		else $error("range error on a non-branch code");

endmodule

/* sim/arm_elf_relocation_patch_unit_test.sv */
// testbench for the arm elf relocation patch unit: directed and random items against a predictor
`timescale 1ns / 100ps

module arm_elf_relocation_patch_unit_test;
	import arp_pkg::*;

	localparam int PIPE_LATENCY = 3;

	// reach of the branch fields, in bytes either side of the place
	localparam logic [31:0] THM_REACH = 32'h00ff_ffff;
	localparam logic [31:0] ARM_REACH = 32'h01ff_ffff;

	// codes that give a patched word
	localparam logic [7:0] PATCH_CODES [13] = '{
		RT_ABS32, RT_REL32, RT_THM_CALL, RT_CALL, RT_JUMP24, RT_TARGET1, RT_V4BX,
		RT_TARGET2, RT_PREL31, RT_MOVW_ABS_NC, RT_MOVT_ABS, RT_THM_MOVW_ABS_NC,
		RT_THM_MOVT_ABS
	};

	typedef struct {
		logic [7:0]  rtype;
		logic [31:0] addend;
		logic [31:0] sym;
		logic [31:0] place;
		logic [31:0] word;
	} reloc_item_t;

	typedef struct {
		logic [7:0]  rtype;
		logic [31:0] word;
		logic [1:0]  st;
	} patch_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  reloc_type;
	logic [31:0] addend;
	logic [31:0] symbol_value;
	logic [31:0] place_address;
	logic [31:0] original_word;
	logic        done;
	logic [31:0] patched_word;
	logic [1:0]  status;

	patch_res_t expected_patches [$];
	int         mismatch_count = 0;

	arm_elf_relocation_patch_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.reloc_type    (reloc_type),
		.addend        (addend),
		.symbol_value  (symbol_value),
		.place_address (place_address),
		.original_word (original_word),
		.done          (done),
		.patched_word  (patched_word),
		.status        (status)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#1000000;
		$display("Verification failed");
		$finish;
	end

	// expected patched word and status for one relocation
	function automatic patch_res_t predict_patch(input reloc_item_t it);
		patch_res_t  res;
		logic [31:0] abs_v;
		logic [31:0] rel_v;
		logic [15:0] imm;
		logic [15:0] hi;
		logic [15:0] lo;
		logic        sgn;
		abs_v = it.sym + it.addend;
		rel_v = abs_v - it.place;
		res.rtype = it.rtype;
		res.word = '0;
		res.st = ST_PATCHED;
		case (it.rtype)
			RT_V4BX: begin
				res.word = (it.word & 32'hf000_000f) | 32'h01a0_f000;
			end
			RT_ABS32, RT_TARGET1: begin
				res.word = abs_v;
			end
			RT_REL32, RT_TARGET2: begin
				res.word = rel_v;
			end
			RT_PREL31: begin
				res.word = {1'b0, rel_v[30:0]};
			end
			RT_THM_CALL: begin
				if ($signed(rel_v) > $signed(THM_REACH) || $signed(rel_v) < -$signed(THM_REACH)) begin
					res.st = ST_RANGE;
				end else begin
					// s at bit 10 of the first halfword, j1/j2 folded with s in the second
					sgn = rel_v[24];
					hi = {it.word[15:11], sgn, rel_v[21:12]};
					lo = {it.word[31:30], sgn ^ ~rel_v[23], it.word[28], sgn ^ ~rel_v[22],
						rel_v[11:1]};
					res.word = {lo, hi};
				end
			end
			RT_CALL, RT_JUMP24: begin
				if ($signed(rel_v) > $signed(ARM_REACH) || $signed(rel_v) < -$signed(ARM_REACH)) begin
					res.st = ST_RANGE;
				end else begin
					res.word = {it.word[31:24], rel_v[25:2]};
				end
			end
			RT_MOVW_ABS_NC, RT_MOVT_ABS: begin
				imm = (it.rtype == RT_MOVT_ABS) ? abs_v[31:16] : abs_v[15:0];
				res.word = {it.word[31:20], imm[15:12], it.word[15:12], imm[11:0]};
			end
			RT_THM_MOVW_ABS_NC, RT_THM_MOVT_ABS: begin
				imm = (it.rtype == RT_THM_MOVT_ABS) ? abs_v[31:16] : abs_v[15:0];
				hi = {it.word[15:11], imm[11], it.word[9:4], imm[15:12]};
				lo = {it.word[31], imm[10:8], it.word[27:24], imm[7:0]};
				res.word = {lo, hi};
			end
			RT_NONE: begin
				res.st = ST_NOP;
			end
			default: begin
				res.st = ST_UNKNOWN;
			end
		endcase
		if (res.st != ST_PATCHED) begin
			res.word = '0;
		end
		return res;
	endfunction

	// drive one item and hold it until accepted; start stays high for a following item
	task automatic send_reloc(input reloc_item_t it);
		start <= 1'b1;
		reloc_type <= it.rtype;
		addend <= it.addend;
		symbol_value <= it.sym;
		place_address <= it.place;
		original_word <= it.word;
		do @(posedge clk); while (busy);
		expected_patches.push_back(predict_patch(it));
	endtask

	// stop sending and wait for every outstanding result, then let the pipeline settle
	task automatic drain_results();
		start <= 1'b0;
		while (expected_patches.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// every code, no-op, unknown codes and field extremes
	task automatic test_reloc_codes();
		send_reloc('{RT_NONE, '1, '1, '1, '1});
		send_reloc('{8'd1, 32'h1234_5678, 32'h8000_0000, 32'h0000_1000, 32'hdead_beef});
		send_reloc('{8'hff, '1, '1, '1, '1});
		send_reloc('{8'd45, '0, '0, '0, '0});
		send_reloc('{RT_V4BX, '0, '0, '0, '1});
		send_reloc('{RT_V4BX, '1, '1, '1, '0});
		send_reloc('{RT_ABS32, '1, '1, '1, '1});
		send_reloc('{RT_TARGET1, 32'h0000_0010, '0, '0, '0});
		send_reloc('{RT_REL32, '0, '0, '1, '0});
		send_reloc('{RT_TARGET2, 32'h0000_0004, 32'h8000_0000, 32'h0000_8000, '1});
		send_reloc('{RT_PREL31, '0, '0, 32'h0000_0004, '1});
		send_reloc('{RT_MOVW_ABS_NC, '1, '1, '0, '0});
		send_reloc('{RT_MOVT_ABS, 32'hfedc_ba98, '0, '0, '1});
		send_reloc('{RT_THM_MOVW_ABS_NC, 32'h0000_a5c3, '0, '0, '1});
		send_reloc('{RT_THM_MOVT_ABS, '1, '0, '1, '0});
		send_reloc('{RT_THM_CALL, 32'hffff_fffc, 32'h0001_0000, 32'h0000_8000, 32'hf800_f000});
		send_reloc('{RT_CALL, 32'hffff_fff8, 32'h0000_2000, 32'h0000_1000, 32'heb00_0000});
		send_reloc('{RT_JUMP24, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000, 32'hea00_0000});
	endtask

	// branch offsets at and just past the edges of their fields
	task automatic test_branch_reach();
		send_reloc('{RT_THM_CALL, THM_REACH, '0, '0, '1});
		send_reloc('{RT_THM_CALL, -THM_REACH, '0, '0, '0});
		send_reloc('{RT_THM_CALL, THM_REACH + 1, '0, '0, '1});
		send_reloc('{RT_THM_CALL, '0, '0, THM_REACH + 1, '1});
		send_reloc('{RT_CALL, ARM_REACH, '0, '0, '1});
		send_reloc('{RT_JUMP24, '0, '0, ARM_REACH, '1});
		send_reloc('{RT_JUMP24, ARM_REACH + 1, '0, '0, '1});
		send_reloc('{RT_CALL, -(ARM_REACH + 1), '0, '0, '1});
	endtask

	// random items, branches steered around their reach
	task automatic test_random_traffic(input int n_items, input int idle_pct);
		reloc_item_t it;
		logic [31:0] reach;
		logic [31:0] off;
		int          pick;
		for (int i = 0; i < n_items; i++) begin
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
			it.addend = $urandom();
			it.sym = ($urandom_range(99) < 15) ? 32'h0 : $urandom();
			it.place = $urandom();
			it.word = $urandom();
			pick = $urandom_range(99);
			if (pick < 8) begin
				it.rtype = $urandom_range(255);
			end else if (pick < 12) begin
				it.rtype = RT_NONE;
			end else begin
				it.rtype = PATCH_CODES[$urandom_range(12)];
			end
			// most branches get an offset near or inside their reach
			if (it.rtype inside {RT_THM_CALL, RT_CALL, RT_JUMP24} && $urandom_range(9) < 8) begin
				reach = (it.rtype == RT_THM_CALL) ? THM_REACH : ARM_REACH;
				case ($urandom_range(2))
					0: off = $urandom_range(2 * reach) - reach;
					1: begin
						off = reach + $urandom_range(4) - 2;
						if ($urandom_range(1)) off = -off;
					end
					default: off = $urandom();
				endcase
				it.addend = it.place - it.sym + off;
			end
			send_reloc(it);
		end
	endtask

	// the sender stops until every result is back, then carries on
	task automatic test_drain_pause();
		test_random_traffic(20, 0);
		drain_results();
		test_random_traffic(20, 0);
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		patch_res_t exp_res;
		if (arst_n && done) begin
			if (expected_patches.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual word %h status %0d",
					$time, patched_word, status);
				mismatch_count++;
			end else begin
				exp_res = expected_patches.pop_front();
				if (patched_word !== exp_res.word) begin
					$display("%0t: patched_word mismatch (type %0d): expected %h, actual %h",
						$time, exp_res.rtype, exp_res.word, patched_word);
					mismatch_count++;
				end
				if (status !== exp_res.st) begin
					$display("%0t: status mismatch (type %0d): expected %0d, actual %0d",
						$time, exp_res.rtype, exp_res.st, status);
					mismatch_count++;
				end
			end
		end
	end

	// test sequence
	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		reloc_type <= '0;
		addend <= '0;
		symbol_value <= '0;
		place_address <= '0;
		original_word <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reloc_codes();
		test_branch_reach();
		test_random_traffic(260, 0);
		test_random_traffic(250, 71);
		test_drain_pause();
		test_random_traffic(240, 0);
		test_random_traffic(240, 37);
		drain_results();

		if (mismatch_count == 0 && expected_patches.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
